// ----- rtl/view_dependent_curvature_core_macros.svh -----
// ----------------------------------------------------------------------------
// View-dependent curvature core: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef VIEW_DEPENDENT_CURVATURE_CORE_MACROS_SVH
`define VIEW_DEPENDENT_CURVATURE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define VDC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VDC_ASSERT(lbl, clk, rst_n, prop, msg)
`define VDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/vdc_pkg.sv -----
// ----------------------------------------------------------------------------
// View-dependent curvature package
// Shared word types, register codes and fixed-point helpers.
// ----------------------------------------------------------------------------
package vdc_pkg;

    typedef enum logic [1:0] {
        CFG_VIEW_X    = 2'd0,
        CFG_VIEW_Y    = 2'd1,
        CFG_VIEW_Z    = 2'd2,
        CFG_THRESHOLD = 2'd3
    } t_cfg_idx;

    localparam logic signed [15:0] ViewXRst = 16'sd0;
    localparam logic signed [15:0] ViewYRst = 16'sd0;
    localparam logic signed [15:0] ViewZRst = 16'sd10240;
    localparam logic signed [31:0] ThrRst   = 32'sd9830;

    localparam logic signed [63:0] OneQ14  = 64'sd16384;
    localparam logic signed [63:0] MinQ14  = -64'sd16384;
    localparam logic signed [63:0] MaxS32  = 64'sd2147483647;
    localparam logic signed [63:0] MinS32  = -64'sd2147483648;

    // vertex attributes that ride along the front of the pipe
    typedef struct packed {
        logic        [47:0] normal;
        logic        [47:0] dir_max;
        logic        [47:0] dir_min;
        logic signed [31:0] curv_max;
        logic signed [31:0] curv_min;
        logic signed [31:0] dcurv_0;
        logic signed [31:0] dcurv_1;
        logic signed [31:0] dcurv_2;
        logic signed [31:0] dcurv_3;
    } t_geo;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] dz;
        t_geo               geo;
    } t_sq_tag;

    typedef struct packed {
        logic neg;
        logic zero;
        t_geo geo;
    } t_w_tag;

    typedef struct packed {
        logic               n_neg;
        logic               p_neg;
        logic               deg;
        logic signed [15:0] fac;
        logic signed [31:0] kr;
        logic signed [33:0] t3;
    } t_nm_tag;

    function automatic logic signed [15:0] comp16(input logic [47:0] vec,
                                                  input int unsigned k);
        return $signed(vec[16*k +: 16]);
    endfunction

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rshr64(input logic signed [63:0] x,
                                                  input int unsigned k);
        logic [63:0] m;
        logic [63:0] r;
        m = x[63] ? 64'(-x) : 64'(x);
        r = (m + (64'd1 << (k - 1))) >> k;
        return x[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                   input logic signed [63:0] lo,
                                                   input logic signed [63:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic logic signed [15:0] dot14(input logic signed [15:0] w0,
                                                 input logic signed [15:0] w1,
                                                 input logic signed [15:0] w2,
                                                 input logic        [47:0] vec);
        logic signed [63:0] acc;
        acc = 64'(w0) * 64'(comp16(vec, 0)) + 64'(w1) * 64'(comp16(vec, 1))
            + 64'(w2) * 64'(comp16(vec, 2));
        return 16'(clamp64(rshr64(acc, 14), MinQ14, OneQ14));
    endfunction

endpackage

// ----- rtl/view_dependent_curvature_core.sv -----
// ----------------------------------------------------------------------------
// View-dependent curvature core
// Per-vertex n.v, radial curvature and suggestive-contour derivative test.
// ----------------------------------------------------------------------------
//
// channel   | handshake            | word
// ----------+----------------------+----------------------------------------
// vertex in | start (busy low)     | position, normal, dirs, curvatures
// result    | o_valid strobe       | facing, radial_curv, numerator, denominator, deg.
// config    | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// One vertex word per cycle; the pipe runs from accept to result strobe through
// the 25-stage square root, the 15-stage view-vector divider and the
// 34-stage numerator/tr divider pair, plus 13 datapath stages.
// busy is never raised; the result cannot be held off, so nothing stalls.
// Synchronous active-low reset clears valid bits and loads config defaults.
// ----------------------------------------------------------------------------
`include "view_dependent_curvature_core_macros.svh"

module view_dependent_curvature_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic        [1:0]  i_cfg_idx,
    input  logic        [31:0] i_cfg_wdata,
    input  logic        [47:0] i_position,
    input  logic        [47:0] i_normal,
    input  logic        [47:0] i_dir_max,
    input  logic        [47:0] i_dir_min,
    input  logic signed [31:0] i_curv_max,
    input  logic signed [31:0] i_curv_min,
    input  logic signed [31:0] i_dcurv_0,
    input  logic signed [31:0] i_dcurv_1,
    input  logic signed [31:0] i_dcurv_2,
    input  logic signed [31:0] i_dcurv_3,
    output logic               o_valid,
    output logic signed [15:0] o_facing,
    output logic signed [31:0] o_radial_curv,
    output logic signed [31:0] o_test_numerator,
    output logic signed [15:0] o_test_denominator,
    output logic               o_degenerate
);
    localparam int SqW     = 50;   // radicand width, root is SqW/2
    localparam int WQ      = 15;   // view component quotient bits
    localparam int TQ      = 34;   // numerator / tr quotient bits
    localparam int PipeLat = 1 + 1 + SqW / 2 + 1 + WQ + 6 + TQ + 4;

    // ---------------- config registers ----------------
    logic signed [15:0] r_view_x, r_view_y, r_view_z;
    logic signed [31:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x <= vdc_pkg::ViewXRst;
            r_view_y <= vdc_pkg::ViewYRst;
            r_view_z <= vdc_pkg::ViewZRst;
            r_thr    <= vdc_pkg::ThrRst;
        end else if (i_cfg_we) begin
            case (vdc_pkg::t_cfg_idx'(i_cfg_idx))
                vdc_pkg::CFG_VIEW_X:    r_view_x <= i_cfg_wdata[15:0];
                vdc_pkg::CFG_VIEW_Y:    r_view_y <= i_cfg_wdata[15:0];
                vdc_pkg::CFG_VIEW_Z:    r_view_z <= i_cfg_wdata[15:0];
                vdc_pkg::CFG_THRESHOLD: r_thr    <= i_cfg_wdata;
                default:                r_thr    <= r_thr;
            endcase
        end
    end

    assign busy = 1'b0;   // fully pipelined, takes a word every cycle

    // ---------------- valid chain (datapath stages) ----------------
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld, r_o_vld;
    logic sq_vld, wd_vld, nd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0; r_b_vld <= 1'b0; r_c_vld <= 1'b0; r_d_vld <= 1'b0;
            r_e_vld <= 1'b0; r_f_vld <= 1'b0; r_g_vld <= 1'b0; r_h_vld <= 1'b0;
            r_i_vld <= 1'b0; r_j_vld <= 1'b0; r_k_vld <= 1'b0; r_l_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            r_a_vld <= start & ~busy;
            r_b_vld <= r_a_vld;
            r_c_vld <= sq_vld;
            r_d_vld <= wd_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_i_vld <= r_h_vld;
            r_j_vld <= nd_vld;
            r_k_vld <= r_j_vld;
            r_l_vld <= r_k_vld;
            r_o_vld <= r_l_vld;
        end
    end

    // ---------------- A: input capture ----------------
    logic [47:0]   r_a_pos;
    vdc_pkg::t_geo r_a_geo;

    always_ff @(posedge i_clk) begin
        r_a_pos          <= i_position;
        r_a_geo.normal   <= i_normal;
        r_a_geo.dir_max  <= i_dir_max;
        r_a_geo.dir_min  <= i_dir_min;
        r_a_geo.curv_max <= i_curv_max;
        r_a_geo.curv_min <= i_curv_min;
        r_a_geo.dcurv_0  <= i_dcurv_0;
        r_a_geo.dcurv_1  <= i_dcurv_1;
        r_a_geo.dcurv_2  <= i_dcurv_2;
        r_a_geo.dcurv_3  <= i_dcurv_3;
    end

    // ---------------- B: eye - vertex, squared length ----------------
    logic signed [16:0] dx, dy, dz;
    logic signed [33:0] px, py, pz;
    vdc_pkg::t_sq_tag   r_b_tag;
    logic        [33:0] r_b_ss;

    assign dx = 17'(r_view_x) - 17'(vdc_pkg::comp16(r_a_pos, 0));
    assign dy = 17'(r_view_y) - 17'(vdc_pkg::comp16(r_a_pos, 1));
    assign dz = 17'(r_view_z) - 17'(vdc_pkg::comp16(r_a_pos, 2));
    assign px = 34'(dx) * 34'(dx);
    assign py = 34'(dy) * 34'(dy);
    assign pz = 34'(dz) * 34'(dz);

    always_ff @(posedge i_clk) begin
        r_b_tag.dx  <= dx;
        r_b_tag.dy  <= dy;
        r_b_tag.dz  <= dz;
        r_b_tag.geo <= r_a_geo;
        r_b_ss      <= unsigned'(px) + unsigned'(py) + unsigned'(pz);
    end

    // length in 2^-20 units: floor(sqrt(ss * 2^16))
    logic [SqW/2-1:0] sq_len;
    vdc_pkg::t_sq_tag sq_tag;

    vdc_isqrt #(
        .IW    (SqW),
        .t_tag (vdc_pkg::t_sq_tag)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_b_vld),
        .i_rad   ({r_b_ss, 16'd0}),
        .i_tag   (r_b_tag),
        .o_vld   (sq_vld),
        .o_root  (sq_len),
        .o_tag   (sq_tag)
    );

    // ---------------- C: rounded dividends for the unit view vector ------
    logic        [16:0]    ax, ay, az;
    logic        [39:0]    r_c_nx, r_c_ny, r_c_nz;
    logic [SqW/2-1:0]      r_c_len;
    vdc_pkg::t_w_tag       r_c_xtag;
    logic                  r_c_yneg, r_c_zneg;

    assign ax = sq_tag.dx[16] ? 17'(-sq_tag.dx) : 17'(sq_tag.dx);
    assign ay = sq_tag.dy[16] ? 17'(-sq_tag.dy) : 17'(sq_tag.dy);
    assign az = sq_tag.dz[16] ? 17'(-sq_tag.dz) : 17'(sq_tag.dz);

    always_ff @(posedge i_clk) begin
        r_c_nx        <= 40'({ax, 22'd0}) + 40'(sq_len[SqW/2-1:1]);
        r_c_ny        <= 40'({ay, 22'd0}) + 40'(sq_len[SqW/2-1:1]);
        r_c_nz        <= 40'({az, 22'd0}) + 40'(sq_len[SqW/2-1:1]);
        r_c_len       <= sq_len;
        r_c_xtag.neg  <= sq_tag.dx[16];
        r_c_xtag.zero <= (sq_len == '0);
        r_c_xtag.geo  <= sq_tag.geo;
        r_c_yneg      <= sq_tag.dy[16];
        r_c_zneg      <= sq_tag.dz[16];
    end

    logic [WQ-1:0]   qx, qy, qz;
    vdc_pkg::t_w_tag wx_tag;
    logic            wy_neg, wz_neg;

    vdc_div #(.NW(40), .DW(SqW/2), .QW(WQ), .t_tag(vdc_pkg::t_w_tag)) u_div_wx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_c_vld),
        .i_num (r_c_nx), .i_den (r_c_len), .i_tag (r_c_xtag),
        .o_vld (wd_vld), .o_quo (qx), .o_tag (wx_tag)
    );
    vdc_div #(.NW(40), .DW(SqW/2), .QW(WQ), .t_tag(logic)) u_div_wy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_c_vld),
        .i_num (r_c_ny), .i_den (r_c_len), .i_tag (r_c_yneg),
        .o_vld (), .o_quo (qy), .o_tag (wy_neg)
    );
    vdc_div #(.NW(40), .DW(SqW/2), .QW(WQ), .t_tag(logic)) u_div_wz (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_c_vld),
        .i_num (r_c_nz), .i_den (r_c_len), .i_tag (r_c_zneg),
        .o_vld (), .o_quo (qz), .o_tag (wz_neg)
    );

    // ---------------- D: signed, clamped view components -----------------
    function automatic logic signed [15:0] wsel(input logic [WQ-1:0] q,
                                                input logic neg, input logic zero);
        logic signed [63:0] m;
        m = vdc_pkg::clamp64(64'(q), 64'sd0, vdc_pkg::OneQ14);
        return zero ? 16'sd0 : (neg ? 16'(-m) : 16'(m));
    endfunction

    logic signed [15:0] r_d_wx, r_d_wy, r_d_wz;
    vdc_pkg::t_geo      r_d_geo;

    always_ff @(posedge i_clk) begin
        r_d_wx  <= wsel(qx, wx_tag.neg, wx_tag.zero);
        r_d_wy  <= wsel(qy, wy_neg, wx_tag.zero);
        r_d_wz  <= wsel(qz, wz_neg, wx_tag.zero);
        r_d_geo <= wx_tag.geo;
    end

    // ---------------- E: facing, u, v -----------------------------------
    logic signed [15:0] r_e_fac, r_e_u, r_e_v;
    vdc_pkg::t_geo      r_e_geo;

    always_ff @(posedge i_clk) begin
        r_e_fac <= vdc_pkg::dot14(r_d_wx, r_d_wy, r_d_wz, r_d_geo.normal);
        r_e_u   <= vdc_pkg::dot14(r_d_wx, r_d_wy, r_d_wz, r_d_geo.dir_max);
        r_e_v   <= vdc_pkg::dot14(r_d_wx, r_d_wy, r_d_wz, r_d_geo.dir_min);
        r_e_geo <= r_d_geo;
    end

    // ---------------- F: u^2, v^2, uv and derivative products -----------
    logic signed [31:0] uu, vv;
    logic signed [17:0] u3, v3;
    logic        [29:0] r_f_u2, r_f_v2;
    logic signed [29:0] r_f_uv;
    logic signed [49:0] r_f_pa0, r_f_pa1, r_f_pb0, r_f_pb1;
    logic signed [47:0] r_f_p3;
    logic signed [32:0] r_f_dc;
    logic signed [31:0] r_f_c1, r_f_c2;
    logic signed [15:0] r_f_fac;

    assign uu = 32'(r_e_u) * 32'(r_e_u);
    assign vv = 32'(r_e_v) * 32'(r_e_v);
    assign u3 = 18'(r_e_u) * 18'sd3;
    assign v3 = 18'(r_e_v) * 18'sd3;

    always_ff @(posedge i_clk) begin
        r_f_u2  <= uu[29:0];
        r_f_v2  <= vv[29:0];
        r_f_uv  <= 30'(32'(r_e_u) * 32'(r_e_v));
        r_f_pa0 <= 50'(r_e_u) * 50'(r_e_geo.dcurv_0);
        r_f_pa1 <= 50'(v3) * 50'(r_e_geo.dcurv_1);
        r_f_pb0 <= 50'(u3) * 50'(r_e_geo.dcurv_2);
        r_f_pb1 <= 50'(r_e_v) * 50'(r_e_geo.dcurv_3);
        r_f_p3  <= 48'(r_thr) * 48'(r_e_fac);
        r_f_dc  <= 33'(r_e_geo.curv_min) - 33'(r_e_geo.curv_max);
        r_f_c1  <= r_e_geo.curv_max;
        r_f_c2  <= r_e_geo.curv_min;
        r_f_fac <= r_e_fac;
    end

    // ---------------- G: a, b, kr products, tr dividend, t3 ------------
    logic signed [34:0] r_g_a, r_g_b;
    logic signed [63:0] r_g_k1, r_g_k2, r_g_p;
    logic signed [33:0] r_g_t3;
    logic        [29:0] r_g_u2, r_g_v2, r_g_den;
    logic               r_g_deg;
    logic signed [15:0] r_g_fac;
    logic        [29:0] den_g;

    assign den_g = r_f_u2 + r_f_v2;

    always_ff @(posedge i_clk) begin
        r_g_a   <= 35'(vdc_pkg::rshr64(64'(r_f_pa0) + 64'(r_f_pa1), 14));
        r_g_b   <= 35'(vdc_pkg::rshr64(64'(r_f_pb0) + 64'(r_f_pb1), 14));
        r_g_k1  <= 64'(r_f_c1) * 64'($signed({1'b0, r_f_u2}));
        r_g_k2  <= 64'(r_f_c2) * 64'($signed({1'b0, r_f_v2}));
        r_g_p   <= 64'(r_f_dc) * 64'(r_f_uv);
        r_g_t3  <= 34'(vdc_pkg::rshr64(64'(r_f_p3), 14));
        r_g_u2  <= r_f_u2;
        r_g_v2  <= r_f_v2;
        r_g_den <= den_g;
        r_g_deg <= (den_g == '0);
        r_g_fac <= r_f_fac;
    end

    // ---------------- H: kr, weighted derivative terms -------------------
    logic signed [63:0] r_h_n1, r_h_n2, r_h_p;
    logic signed [31:0] r_h_kr;
    logic signed [33:0] r_h_t3;
    logic        [29:0] r_h_den;
    logic               r_h_deg;
    logic signed [15:0] r_h_fac;

    always_ff @(posedge i_clk) begin
        r_h_n1  <= 64'($signed({1'b0, r_g_u2})) * 64'(r_g_a);
        r_h_n2  <= 64'($signed({1'b0, r_g_v2})) * 64'(r_g_b);
        r_h_kr  <= 32'(vdc_pkg::clamp64(vdc_pkg::rshr64(r_g_k1 + r_g_k2, 28),
                                        vdc_pkg::MinS32, vdc_pkg::MaxS32));
        r_h_p   <= r_g_p;
        r_h_t3  <= r_g_t3;
        r_h_den <= r_g_den;
        r_h_deg <= r_g_deg;
        r_h_fac <= r_g_fac;
    end

    // ---------------- I: rounded magnitudes for the two divides ---------
    logic signed [63:0] nsum;
    logic        [63:0] absn, absp;
    logic        [62:0] r_i_nn, r_i_np;
    logic        [29:0] r_i_den;
    vdc_pkg::t_nm_tag   r_i_tag;

    assign nsum = r_h_n1 + r_h_n2;
    assign absn = nsum[63]  ? 64'(-nsum)  : 64'(nsum);
    assign absp = r_h_p[63] ? 64'(-r_h_p) : 64'(r_h_p);

    always_ff @(posedge i_clk) begin
        r_i_nn        <= 63'(absn + 64'(r_h_den[29:1]));
        r_i_np        <= 63'(absp + 64'(r_h_den[29:1]));
        r_i_den       <= r_h_den;
        r_i_tag.n_neg <= nsum[63];
        r_i_tag.p_neg <= r_h_p[63];
        r_i_tag.deg   <= r_h_deg;
        r_i_tag.fac   <= r_h_fac;
        r_i_tag.kr    <= r_h_kr;
        r_i_tag.t3    <= r_h_t3;
    end

    logic [TQ-1:0]    q_t1, q_tr;
    vdc_pkg::t_nm_tag nd_tag;
    logic             tr_neg;

    vdc_div #(.NW(63), .DW(30), .QW(TQ), .t_tag(vdc_pkg::t_nm_tag)) u_div_t1 (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_i_vld),
        .i_num (r_i_nn), .i_den (r_i_den), .i_tag (r_i_tag),
        .o_vld (nd_vld), .o_quo (q_t1), .o_tag (nd_tag)
    );
    vdc_div #(.NW(63), .DW(30), .QW(TQ), .t_tag(logic)) u_div_tr (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (r_i_vld),
        .i_num (r_i_np), .i_den (r_i_den), .i_tag (r_i_tag.p_neg),
        .o_vld (), .o_quo (q_tr), .o_tag (tr_neg)
    );

    // ---------------- J..L: tr^2 and 2*facing*tr^2 ----------------------
    // |tr| <= 2^31, so the low 32 quotient bits carry its magnitude
    logic signed [63:0] r_j_t1, r_k_t1, r_l_t1;
    logic        [63:0] r_j_sq;
    logic        [46:0] r_k_tr2;
    logic signed [63:0] r_l_prod;
    vdc_pkg::t_nm_tag   r_j_tag, r_k_tag, r_l_tag;

    always_ff @(posedge i_clk) begin
        r_j_t1   <= nd_tag.n_neg ? -64'(q_t1) : 64'(q_t1);
        r_j_sq   <= 64'(q_tr[31:0]) * 64'(q_tr[31:0]);
        r_j_tag  <= nd_tag;
        r_k_t1   <= r_j_t1;
        r_k_tr2  <= 47'((r_j_sq + 64'd32768) >> 16);
        r_k_tag  <= r_j_tag;
        r_l_t1   <= r_k_t1;
        r_l_prod <= 64'(r_k_tag.fac) * 64'($signed({1'b0, r_k_tr2}));
        r_l_tag  <= r_k_tag;
    end

    // ---------------- M: numerator, output register ---------------------
    logic signed [63:0] t2, diff;
    logic signed [15:0] r_o_fac;
    logic signed [31:0] r_o_kr, r_o_num;
    logic               r_o_deg;

    assign t2   = vdc_pkg::rshr64(r_l_prod <<< 1, 14);
    assign diff = r_l_t1 - t2 - 64'(r_l_tag.t3);

    always_ff @(posedge i_clk) begin
        r_o_fac <= r_l_tag.fac;
        r_o_kr  <= r_l_tag.kr;
        r_o_deg <= r_l_tag.deg;
        r_o_num <= r_l_tag.deg ? 32'sd0 :
                   32'(vdc_pkg::clamp64(diff, vdc_pkg::MinS32, vdc_pkg::MaxS32));
    end

    assign o_valid            = r_o_vld;
    assign o_facing           = r_o_fac;
    assign o_radial_curv      = r_o_kr;
    assign o_test_numerator   = r_o_num;
    assign o_test_denominator = r_o_fac;
    assign o_degenerate       = r_o_deg;

    // tr sign is carried in both tags; they must agree at the divider exit
    logic tr_sign_ok;
    assign tr_sign_ok = (tr_neg == nd_tag.p_neg);

    // ---------------- assertions ----------------
    `VDC_ASSERT(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##PipeLat o_valid, "result strobe missing after accept")
    `VDC_ASSERT(a_no_ghost, i_clk, i_rst_n, o_valid |-> $past(start && !busy, PipeLat), "result strobe without accept")
    `VDC_ASSERT(a_deg_zero, i_clk, i_rst_n, (o_valid && o_degenerate) |-> (o_test_numerator == 32'sd0), "degenerate word with nonzero numerator")
    `VDC_ASSERT(a_tr_align, i_clk, i_rst_n, nd_vld |-> tr_sign_ok, "divider pair out of step")

endmodule

// ----- rtl/vdc_isqrt.sv -----
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor result, tag and valid travel alongside.
// ----------------------------------------------------------------------------
module vdc_isqrt #(
    parameter int  IW = 50,
    parameter type t_tag = logic
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [IW-1:0]     i_rad,
    input  t_tag              i_tag,
    output logic              o_vld,
    output logic [IW/2-1:0]   o_root,
    output t_tag              o_tag
);
    localparam int OW = IW / 2;

    logic [IW-1:0] r_s [0:OW-1];
    logic [IW-1:0] r_r [0:OW-1];
    logic          r_v [0:OW-1];
    t_tag          r_t [0:OW-1];

    for (genvar gk = 0; gk < OW; gk++) begin : g_stage
        localparam logic [IW-1:0] StepBit = {{(IW-1){1'b0}}, 1'b1} << (2 * (OW - 1 - gk));
        logic [IW-1:0] s_in;
        logic [IW-1:0] r_in;
        logic          v_in;
        t_tag          t_in;
        logic [IW-1:0] trial;
        if (gk == 0) begin : g_first
            assign s_in = i_rad;
            assign r_in = '0;
            assign v_in = i_vld;
            assign t_in = i_tag;
        end else begin : g_next
            assign s_in = r_s[gk-1];
            assign r_in = r_r[gk-1];
            assign v_in = r_v[gk-1];
            assign t_in = r_t[gk-1];
        end
        assign trial = r_in + StepBit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else begin
                r_v[gk] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_t[gk] <= t_in;
            if (s_in >= trial) begin
                r_s[gk] <= s_in - trial;
                r_r[gk] <= (r_in >> 1) + StepBit;
            end else begin
                r_s[gk] <= s_in;
                r_r[gk] <= r_in >> 1;
            end
        end
    end

    assign o_vld  = r_v[OW-1];
    assign o_root = r_r[OW-1][OW-1:0];
    assign o_tag  = r_t[OW-1];
endmodule

// ----- rtl/vdc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; caller keeps num below den * 2^QW.
// ----------------------------------------------------------------------------
module vdc_div #(
    parameter int  NW = 40,
    parameter int  DW = 25,
    parameter int  QW = 15,
    parameter type t_tag = logic
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  t_tag          i_tag,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output t_tag          o_tag
);
    localparam int XW = (NW > DW + QW) ? NW : DW + QW;

    logic [XW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW-1];
    logic          r_v   [0:QW-1];
    t_tag          r_t   [0:QW-1];

    for (genvar gk = 0; gk < QW; gk++) begin : g_stage
        logic [XW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic          v_in;
        t_tag          t_in;
        logic [XW-1:0] sub;
        if (gk == 0) begin : g_first
            assign rem_in = XW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign v_in   = i_vld;
            assign t_in   = i_tag;
        end else begin : g_next
            assign rem_in = r_rem[gk-1];
            assign den_in = r_den[gk-1];
            assign quo_in = r_quo[gk-1];
            assign v_in   = r_v[gk-1];
            assign t_in   = r_t[gk-1];
        end
        assign sub = XW'(den_in) << (QW - 1 - gk);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gk] <= 1'b0;
            end else begin
                r_v[gk] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_den[gk] <= den_in;
            r_t[gk]   <= t_in;
            if (rem_in >= sub) begin
                r_rem[gk] <= rem_in - sub;
                r_quo[gk] <= quo_in | (QW'(1) << (QW - 1 - gk));
            end else begin
                r_rem[gk] <= rem_in;
                r_quo[gk] <= quo_in;
            end
        end
    end

    assign o_vld = r_v[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_tag = r_t[QW-1];
endmodule
